### hdl/gpio_pkg.sv
// Shared types, register word addresses and constants of the GPIO port.
// Used by gpio_core and gpio_port_with_interrupts; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gpio_pkg;

	// Pin count and the number of pad registers.
	localparam int NumPinsDef = 8;
	localparam int PadCount = 9;
	localparam int PadIdxW = $clog2(PadCount);

	// Command codes of an input beat.
	localparam logic [1:0] CmdRead = 2'd0;
	localparam logic [1:0] CmdWrite = 2'd1;
	localparam logic [1:0] CmdPin = 2'd2;

	// Byte offset boundaries and the lock key.
	localparam logic [11:0] WindowEnd = 12'h400;
	localparam logic [11:0] IdBase = 12'hfd0;
	localparam logic [31:0] LockKey = 32'h0acce551;

	// Register word addresses, offset[11:2].
	localparam logic [9:0] AddrDir = 10'h100;
	localparam logic [9:0] AddrSense = 10'h101;
	localparam logic [9:0] AddrBoth = 10'h102;
	localparam logic [9:0] AddrPol = 10'h103;
	localparam logic [9:0] AddrMask = 10'h104;
	localparam logic [9:0] AddrRaw = 10'h105;
	localparam logic [9:0] AddrMis = 10'h106;
	localparam logic [9:0] AddrIcr = 10'h107;
	localparam logic [9:0] AddrAlt = 10'h108;
	localparam logic [9:0] AddrLock = 10'h148;
	localparam logic [9:0] AddrCommit = 10'h149;
	localparam logic [9:0] AddrPadLast = 10'h14a;
	// Pad registers 0..7 share offset[11:5].
	localparam logic [6:0] PadGroup = 7'h28;

	// One input beat.
	typedef struct packed {
		logic [1:0]  command;
		logic [11:0] offset;
		logic [31:0] write_data;
		logic [2:0]  pin_index;
		logic        pin_level;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] read_data;
		logic       access_error;
		logic [7:0] pin_out;
		logic       irq_out;
	} result_t;

	// Mask of the implemented pins.
	function automatic logic [7:0] pin_mask(input int n);
		logic [8:0] full;
		full = (9'd1 << n) - 9'd1;
		return full[7:0];
	endfunction

	// Identification bytes, one per word from IdBase.
	function automatic logic [7:0] id_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd4: b = 8'h61;
			4'd5: b = 8'h10;
			4'd6: b = 8'h04;
			4'd8: b = 8'h0d;
			4'd9: b = 8'hf0;
			4'd10: b = 8'h05;
			4'd11: b = 8'hb1;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### hdl/gpio_port_with_interrupts.sv
// GPIO port top level: input register, core, result register, config port.
// A beat goes from the input register through the core into the result register.
// Throughput: one beat per cycle while out_stall does not hold a result; the core's state updates once per beat.
// A result held by out_stall does not block intake while the input stage is free.
// Reset (arst_n low, asynchronous): all inputs, commit locked with a mask of all implemented pins, no status.
// Depends on gpio_pkg and gpio_core.
`timescale 1ns / 1ps
`default_nettype none

module gpio_port_with_interrupts #(
	parameter int NUM_PINS = gpio_pkg::NumPinsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [11:0] offset,
	input  wire logic [31:0] write_data,
	input  wire logic [2:0]  pin_index,
	input  wire logic        pin_level,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  read_data,
	output      logic        access_error,
	output      logic [7:0]  pin_out,
	output      logic        irq_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);
	import gpio_pkg::*;

	localparam logic [7:0] PinMask = pin_mask(NUM_PINS);

	item_t   item_s1;
	logic    valid_s1;
	result_t core_res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    accept;
	logic [7:0] invert_q;

	// The input stage moves into the result register when that is free or drained.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{command: command, offset: offset, write_data: write_data,
				pin_index: pin_index, pin_level: pin_level};
		end
	end

	gpio_core #(
		.NUM_PINS(NUM_PINS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.item(item_s1),
		.input_invert(invert_q),
		.result(core_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = res_q.read_data;
	assign access_error = res_q.access_error;
	assign pin_out = res_q.pin_out;
	assign irq_out = res_q.irq_out;

	// Configuration port: input inversion register at byte address zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 8'h00;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			invert_q <= pwdata[7:0] & PinMask;
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {24'd0, invert_q};

endmodule

`default_nettype wire

### hdl/gpio_core.sv
// Register file, bus decode and interrupt detection of the GPIO port.
// Depends on gpio_pkg; state advances on each fired item.
`timescale 1ns / 1ps
`default_nettype none

module gpio_core #(
	parameter int NUM_PINS = gpio_pkg::NumPinsDef
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire gpio_pkg::item_t  item,
	input  wire logic [7:0]       input_invert,
	output gpio_pkg::result_t     result
);
	import gpio_pkg::*;

	localparam logic [7:0] PinMask = pin_mask(NUM_PINS);
	localparam logic [3:0] NumPinsW = 4'(NUM_PINS);
	localparam logic [PadIdxW-1:0] PadLastIdx = PadIdxW'(PadCount - 1);

	logic [7:0] data_q, last_q, dir_q, sense_q, both_q, pol_q, mask_q, raw_q, alt_q, commit_q;
	logic       lock_q;
	logic [7:0] pad_q [PadCount];

	logic [7:0] n_data, n_last, n_dir, n_sense, n_both, n_pol, n_mask, n_raw, n_alt, n_commit;
	logic       n_lock;
	logic       pad_we;
	logic [PadIdxW-1:0] pad_widx;
	logic       run_detect;
	logic [7:0] rd, v, wmask, pmask, changed, match;
	logic       err, lvl;
	logic [9:0] word;
	logic [11:0] id_off;

	assign word = item.offset[11:2];
	assign id_off = item.offset - IdBase;
	assign v = item.write_data[7:0] & PinMask;

	// Decode the beat, then run edge and level detection on the new state.
	always_comb begin
		n_data = data_q;
		n_last = last_q;
		n_dir = dir_q;
		n_sense = sense_q;
		n_both = both_q;
		n_pol = pol_q;
		n_mask = mask_q;
		n_raw = raw_q;
		n_alt = alt_q;
		n_commit = commit_q;
		n_lock = lock_q;
		pad_we = 1'b0;
		pad_widx = {1'b0, item.offset[4:2]};
		run_detect = 1'b0;
		rd = 8'h00;
		err = 1'b0;
		wmask = word[7:0] & dir_q;
		pmask = 8'h01 << item.pin_index;
		lvl = item.pin_level ^ input_invert[item.pin_index];
		changed = 8'h00;
		match = 8'h00;

		case (item.command)
			CmdRead: begin
				if (item.offset >= IdBase) begin
					rd = id_byte(id_off[5:2]);
				end else if (item.offset < WindowEnd) begin
					rd = data_q & word[7:0];
				end else begin
					case (word)
						AddrDir: rd = dir_q;
						AddrSense: rd = sense_q;
						AddrBoth: rd = both_q;
						AddrPol: rd = pol_q;
						AddrMask: rd = mask_q;
						AddrRaw: rd = raw_q;
						AddrMis: rd = raw_q & mask_q;
						AddrAlt: rd = alt_q;
						AddrLock: rd = {7'd0, lock_q};
						AddrCommit: rd = commit_q;
						AddrPadLast: rd = pad_q[PadLastIdx];
						default: begin
							if (word[9:3] == PadGroup) begin
								rd = pad_q[{1'b0, item.offset[4:2]}];
							end else begin
								err = 1'b1;
							end
						end
					endcase
				end
			end
			CmdWrite: begin
				run_detect = 1'b1;
				if (item.offset < WindowEnd) begin
					n_data = (data_q & ~wmask) | (v & wmask);
				end else begin
					case (word)
						AddrDir: n_dir = v;
						AddrSense: n_sense = v;
						AddrBoth: n_both = v;
						AddrPol: n_pol = v;
						AddrMask: n_mask = v;
						AddrIcr: n_raw = raw_q & ~v;
						AddrAlt: n_alt = (alt_q & ~commit_q) | (v & commit_q);
						AddrLock: n_lock = (item.write_data != LockKey);
						AddrCommit: begin
							if (!lock_q) begin
								n_commit = v;
							end
						end
						AddrPadLast: begin
							pad_we = 1'b1;
							pad_widx = PadLastIdx;
						end
						default: begin
							if (word[9:3] == PadGroup) begin
								pad_we = 1'b1;
							end else begin
								err = 1'b1;
								run_detect = 1'b0;
							end
						end
					endcase
				end
			end
			CmdPin: begin
				if (({1'b0, item.pin_index} < NumPinsW) && ((dir_q & pmask) == 8'h00)) begin
					run_detect = 1'b1;
					n_data = lvl ? (data_q | pmask) : (data_q & ~pmask);
				end
			end
			default: begin
			end
		endcase

		// Edge events update the last seen level; level events are sticky too.
		if (run_detect) begin
			changed = (n_last ^ n_data) & ~n_dir;
			match = ~(n_data ^ n_pol);
			if (changed != 8'h00) begin
				n_last = n_data;
				n_raw = n_raw | (changed & ~n_sense & (n_both | match));
			end
			n_raw = (n_raw | (match & n_sense)) & PinMask;
		end

		result.read_data = rd;
		result.access_error = err;
		result.pin_out = ((n_data & n_dir) | ~n_dir) & PinMask;
		result.irq_out = ((n_raw & n_mask) != 8'h00);
	end

	// State registers, written once per fired beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= 8'h00;
			last_q <= 8'h00;
			dir_q <= 8'h00;
			sense_q <= 8'h00;
			both_q <= 8'h00;
			pol_q <= 8'h00;
			mask_q <= 8'h00;
			raw_q <= 8'h00;
			alt_q <= 8'h00;
			commit_q <= PinMask;
			lock_q <= 1'b1;
			for (int i = 0; i < PadCount; i++) begin
				pad_q[i] <= (i == 0) ? PinMask : 8'h00;
			end
		end else if (fire) begin
			data_q <= n_data;
			last_q <= n_last;
			dir_q <= n_dir;
			sense_q <= n_sense;
			both_q <= n_both;
			pol_q <= n_pol;
			mask_q <= n_mask;
			raw_q <= n_raw;
			alt_q <= n_alt;
			commit_q <= n_commit;
			lock_q <= n_lock;
			if (pad_we) begin
				pad_q[pad_widx] <= v;
			end
		end
	end

endmodule

`default_nettype wire
